// ----- hw/rtl/ascp_pkg.sv -----
// shared types and constants for the asctime date string parser
package ascp_pkg;

  // one-hot position within the date line
  typedef enum logic [6:0] {
    FIELD_WEEK   = 7'b0000001,
    FIELD_MONTH  = 7'b0000010,
    FIELD_DAY    = 7'b0000100,
    FIELD_HOUR   = 7'b0001000,
    FIELD_MINUTE = 7'b0010000,
    FIELD_SECOND = 7'b0100000,
    FIELD_YEAR   = 7'b1000000
  } field_t;

  localparam logic [7:0] NL_BYTE    = 8'h0A;
  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam logic [7:0] COLON_BYTE = 8'h3A;
  localparam logic [7:0] DIGIT_LO   = 8'h30;
  localparam logic [7:0] DIGIT_HI   = 8'h39;

  localparam logic [2:0] WD_SUN = 3'd0;
  localparam logic [2:0] WD_MON = 3'd1;
  localparam logic [2:0] WD_TUE = 3'd2;
  localparam logic [2:0] WD_WED = 3'd3;
  localparam logic [2:0] WD_THU = 3'd4;
  localparam logic [2:0] WD_FRI = 3'd5;
  localparam logic [2:0] WD_SAT = 3'd6;

  localparam logic [3:0] MON_NONE = 4'd0;
  localparam logic [3:0] MON_JAN  = 4'd1;
  localparam logic [3:0] MON_FEB  = 4'd2;
  localparam logic [3:0] MON_MAR  = 4'd3;
  localparam logic [3:0] MON_APR  = 4'd4;
  localparam logic [3:0] MON_MAY  = 4'd5;
  localparam logic [3:0] MON_JUN  = 4'd6;
  localparam logic [3:0] MON_JUL  = 4'd7;
  localparam logic [3:0] MON_AUG  = 4'd8;
  localparam logic [3:0] MON_SEP  = 4'd9;
  localparam logic [3:0] MON_OCT  = 4'd10;
  localparam logic [3:0] MON_NOV  = 4'd11;
  localparam logic [3:0] MON_DEC  = 4'd12;

  typedef struct packed {
    logic [2:0]  weekday;
    logic [3:0]  month_num;
    logic [6:0]  day_of_month;
    logic [7:0]  hour_val;
    logic [7:0]  minute_val;
    logic [7:0]  second_val;
    logic [15:0] year_val;
    logic        name_error;
  } result_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= DIGIT_LO) && (b <= DIGIT_HI);
  endfunction

endpackage

// ----- hw/rtl/ascp_in_reg.sv -----
// input byte register with valid/ready handshake
module ascp_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] byte_in,
  input  logic       take,
  output logic       hold_valid,
  output logic [7:0] hold_byte
);

  // refill in the same cycle the held byte is consumed
  assign in_ready = !hold_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte <= byte_in;
    end
  end

endmodule

// ----- hw/rtl/ascp_field_decoder.sv -----
// field tracking and running values for one date line
module ascp_field_decoder (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        byte_q,
  output logic              emit,
  output ascp_pkg::result_t result
);

  ascp_pkg::field_t field, field_next;
  logic [1:0]  char_index, char_index_next;
  logic [2:0]  week_code, week_code_next;
  logic [3:0]  month_code, month_code_next;
  logic        bad_name, bad_name_next;
  logic [6:0]  day_acc, day_acc_next;
  logic [7:0]  hour_acc, hour_acc_next;
  logic [7:0]  minute_acc, minute_acc_next;
  logic [7:0]  second_acc, second_acc_next;
  logic [15:0] year_acc, year_acc_next;
  logic        digits_done, digits_done_next;

  logic       is_nl, is_space, is_colon, dig, num_take, num_stop;
  logic [3:0] dval;

  assign is_nl    = (byte_q == ascp_pkg::NL_BYTE);
  assign is_space = (byte_q == ascp_pkg::SPACE_BYTE);
  assign is_colon = (byte_q == ascp_pkg::COLON_BYTE);
  assign dig      = ascp_pkg::is_digit(byte_q);
  assign dval     = byte_q[3:0];
  assign emit     = step && is_nl;

  // shared digit intake rule of hour, minute, second and year
  assign num_take = !digits_done && dig;
  assign num_stop = !digits_done && !dig && !(is_space && (char_index == 2'd0));

  assign result.weekday      = week_code;
  assign result.month_num    = month_code;
  assign result.day_of_month = day_acc;
  assign result.hour_val     = hour_acc;
  assign result.minute_val   = minute_acc;
  assign result.second_val   = second_acc;
  assign result.year_val     = year_acc;
  assign result.name_error   = bad_name || (month_code == ascp_pkg::MON_NONE);

  always_comb begin
    field_next       = field;
    char_index_next  = char_index;
    week_code_next   = week_code;
    month_code_next  = month_code;
    bad_name_next    = bad_name;
    day_acc_next     = day_acc;
    hour_acc_next    = hour_acc;
    minute_acc_next  = minute_acc;
    second_acc_next  = second_acc;
    year_acc_next    = year_acc;
    digits_done_next = digits_done;
    priority if (is_nl) begin
      field_next       = ascp_pkg::FIELD_WEEK;
      char_index_next  = 2'd0;
      week_code_next   = ascp_pkg::WD_SUN;
      month_code_next  = ascp_pkg::MON_NONE;
      bad_name_next    = 1'b0;
      day_acc_next     = '0;
      hour_acc_next    = '0;
      minute_acc_next  = '0;
      second_acc_next  = '0;
      year_acc_next    = '0;
      digits_done_next = 1'b0;
    end else begin
      unique case (field)
        ascp_pkg::FIELD_WEEK: begin
          if (char_index != 2'd0 && is_space) begin
            field_next       = ascp_pkg::FIELD_MONTH;
            char_index_next  = 2'd0;
            digits_done_next = 1'b0;
          end else begin
            if (char_index == 2'd0) begin
              unique case (byte_q)
                "S":     week_code_next = ascp_pkg::WD_SUN;
                "M":     week_code_next = ascp_pkg::WD_MON;
                "T":     week_code_next = ascp_pkg::WD_TUE;
                "W":     week_code_next = ascp_pkg::WD_WED;
                "F":     week_code_next = ascp_pkg::WD_FRI;
                default: begin
                  week_code_next = ascp_pkg::WD_SUN;
                  bad_name_next  = 1'b1;
                end
              endcase
            end else if (char_index == 2'd1) begin
              if (byte_q == "a" && week_code == ascp_pkg::WD_SUN && !bad_name) begin
                week_code_next = ascp_pkg::WD_SAT;
              end else if (byte_q == "h" && week_code == ascp_pkg::WD_TUE) begin
                week_code_next = ascp_pkg::WD_THU;
              end
            end
            if (char_index != 2'd3) char_index_next = char_index + 2'd1;
          end
        end
        ascp_pkg::FIELD_MONTH: begin
          if (is_space) begin
            field_next       = ascp_pkg::FIELD_DAY;
            char_index_next  = 2'd0;
            digits_done_next = 1'b0;
          end else begin
            if (char_index == 2'd0) begin
              unique case (byte_q)
                "J":     month_code_next = ascp_pkg::MON_JAN;
                "F":     month_code_next = ascp_pkg::MON_FEB;
                "M":     month_code_next = ascp_pkg::MON_MAR;
                "A":     month_code_next = ascp_pkg::MON_APR;
                "S":     month_code_next = ascp_pkg::MON_SEP;
                "O":     month_code_next = ascp_pkg::MON_OCT;
                "N":     month_code_next = ascp_pkg::MON_NOV;
                "D":     month_code_next = ascp_pkg::MON_DEC;
                default: begin
                  month_code_next = ascp_pkg::MON_NONE;
                  bad_name_next   = 1'b1;
                end
              endcase
            end else if (char_index == 2'd1) begin
              if (byte_q == "u" && month_code == ascp_pkg::MON_JAN) begin
                month_code_next = ascp_pkg::MON_JUN;
              end else if (byte_q == "u" && month_code == ascp_pkg::MON_APR) begin
                month_code_next = ascp_pkg::MON_AUG;
              end
            end else if (char_index == 2'd2) begin
              if (byte_q == "l" && month_code == ascp_pkg::MON_JUN) begin
                month_code_next = ascp_pkg::MON_JUL;
              end else if (byte_q == "y" && month_code == ascp_pkg::MON_MAR) begin
                month_code_next = ascp_pkg::MON_MAY;
              end
            end
            if (char_index != 2'd3) char_index_next = char_index + 2'd1;
          end
        end
        ascp_pkg::FIELD_DAY: begin
          if (!digits_done) begin
            if (dig) begin
              day_acc_next = 7'(({3'b000, day_acc} << 3) + ({3'b000, day_acc} << 1)
                                + {6'd0, dval});
            end else if (!is_space) begin
              digits_done_next = 1'b1;
            end
          end
          // exactly two bytes in the day field
          if (char_index == 2'd1) begin
            field_next       = ascp_pkg::FIELD_HOUR;
            char_index_next  = 2'd0;
            digits_done_next = 1'b0;
          end else begin
            char_index_next = char_index + 2'd1;
          end
        end
        ascp_pkg::FIELD_HOUR: begin
          if (is_colon) begin
            field_next       = ascp_pkg::FIELD_MINUTE;
            char_index_next  = 2'd0;
            digits_done_next = 1'b0;
          end else if (num_take) begin
            hour_acc_next   = 8'((hour_acc << 3) + (hour_acc << 1) + {4'd0, dval});
            char_index_next = 2'd1;
          end else if (num_stop) begin
            digits_done_next = 1'b1;
          end
        end
        ascp_pkg::FIELD_MINUTE: begin
          if (is_colon) begin
            field_next       = ascp_pkg::FIELD_SECOND;
            char_index_next  = 2'd0;
            digits_done_next = 1'b0;
          end else if (num_take) begin
            minute_acc_next = 8'((minute_acc << 3) + (minute_acc << 1) + {4'd0, dval});
            char_index_next = 2'd1;
          end else if (num_stop) begin
            digits_done_next = 1'b1;
          end
        end
        ascp_pkg::FIELD_SECOND: begin
          if (is_space) begin
            field_next       = ascp_pkg::FIELD_YEAR;
            char_index_next  = 2'd0;
            digits_done_next = 1'b0;
          end else if (num_take) begin
            second_acc_next = 8'((second_acc << 3) + (second_acc << 1) + {4'd0, dval});
            char_index_next = 2'd1;
          end else if (num_stop) begin
            digits_done_next = 1'b1;
          end
        end
        ascp_pkg::FIELD_YEAR: begin
          // trailing bytes stay in the year field
          if (num_take) begin
            year_acc_next   = 16'((year_acc << 3) + (year_acc << 1) + {12'd0, dval});
            char_index_next = 2'd1;
          end else if (num_stop) begin
            digits_done_next = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field       <= ascp_pkg::FIELD_WEEK;
      char_index  <= 2'd0;
      week_code   <= ascp_pkg::WD_SUN;
      month_code  <= ascp_pkg::MON_NONE;
      bad_name    <= 1'b0;
      day_acc     <= '0;
      hour_acc    <= '0;
      minute_acc  <= '0;
      second_acc  <= '0;
      year_acc    <= '0;
      digits_done <= 1'b0;
    end else if (step) begin
      field       <= field_next;
      char_index  <= char_index_next;
      week_code   <= week_code_next;
      month_code  <= month_code_next;
      bad_name    <= bad_name_next;
      day_acc     <= day_acc_next;
      hour_acc    <= hour_acc_next;
      minute_acc  <= minute_acc_next;
      second_acc  <= second_acc_next;
      year_acc    <= year_acc_next;
      digits_done <= digits_done_next;
    end
  end

  a_line_restart: assert property (@(posedge clk) disable iff (rst)
    emit |=> (field == ascp_pkg::FIELD_WEEK && char_index == 2'd0 && !bad_name))
    else $error("state not cleared after newline");

  a_day_two_bytes: assert property (@(posedge clk) disable iff (rst)
    (field == ascp_pkg::FIELD_DAY) |-> (char_index == 2'd0 || char_index == 2'd1))
    else $error("day field ran past two bytes");

  a_bad_name_code: assert property (@(posedge clk) disable iff (rst)
    bad_name |-> (week_code == ascp_pkg::WD_SUN || month_code == ascp_pkg::MON_NONE))
    else $error("unknown name left a nonzero code");

endmodule

// ----- hw/rtl/ascp_out_reg.sv -----
// result register with valid/ready handshake
module ascp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  ascp_pkg::result_t result,
  output logic              out_free,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        weekday,
  output logic [3:0]        month_num,
  output logic [6:0]        day_of_month,
  output logic [7:0]        hour_val,
  output logic [7:0]        minute_val,
  output logic [7:0]        second_val,
  output logic [15:0]       year_val,
  output logic              name_error
);

  ascp_pkg::result_t held;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && out_free) begin
      held <= result;
    end
  end

  assign weekday      = held.weekday;
  assign month_num    = held.month_num;
  assign day_of_month = held.day_of_month;
  assign hour_val     = held.hour_val;
  assign minute_val   = held.minute_val;
  assign second_val   = held.second_val;
  assign year_val     = held.year_val;
  assign name_error   = held.name_error;

endmodule

// ----- hw/rtl/asctime_date_string_parser_core.sv -----
// Streaming parser for ctime-style date lines "Www Mmm dd hh:mm:ss yyyy\n": one byte is
// transferred per cycle, registered, then decoded in the next cycle against the field
// state; a newline loads one result into the output register, so a result is offered the
// cycle after its newline leaves the input register. Sustained rate is one byte per clock;
// the only stall is a newline meeting an output register that is still full and not being
// taken. Every other byte produces no result.
module asctime_date_string_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  weekday,
  output logic [3:0]  month_num,
  output logic [6:0]  day_of_month,
  output logic [7:0]  hour_val,
  output logic [7:0]  minute_val,
  output logic [7:0]  second_val,
  output logic [15:0] year_val,
  output logic        name_error
);

  logic              hold_valid;
  logic [7:0]        hold_byte;
  logic              take;
  logic              emit;
  logic              out_free;
  ascp_pkg::result_t result;

  // a newline needs room in the result register, anything else always proceeds
  assign take = hold_valid && ((hold_byte != ascp_pkg::NL_BYTE) || out_free);

  ascp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .byte_in    (byte_in),
    .take       (take),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte)
  );

  ascp_field_decoder u_decoder (
    .clk    (clk),
    .rst    (rst),
    .step   (take),
    .byte_q (hold_byte),
    .emit   (emit),
    .result (result)
  );

  ascp_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (emit),
    .result       (result),
    .out_free     (out_free),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .weekday      (weekday),
    .month_num    (month_num),
    .day_of_month (day_of_month),
    .hour_val     (hour_val),
    .minute_val   (minute_val),
    .second_val   (second_val),
    .year_val     (year_val),
    .name_error   (name_error)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free)
    else $error("result emitted into a full output register");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    emit |=> out_valid)
    else $error("emitted result not offered");

endmodule
